[hw/rtl/ags_pkg.sv]
`timescale 1ns / 1ps

package ags_pkg;

   localparam int REQ_TDATA_W = 136;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 24;

   localparam int TIME_W   = 32;
   localparam int SAMPLE_W = 16;
   localparam int MAG_W    = 17;
   localparam int SQ_W     = 31;
   localparam int SUM_W    = 32;
   localparam int THR_W    = 39;
   localparam int GAIN_W   = 20;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BASE_GAIN   = 3'd0,
      CSR_RESET_GAIN  = 3'd1,
      CSR_QUIET_TIME  = 3'd2,
      CSR_ACTIVE_TIME = 3'd3,
      CSR_GYRO_LIMIT  = 3'd4,
      CSR_ONE_G       = 3'd5
   } csr_index_type;

   localparam logic [15:0] BASE_GAIN_RST   = 16'd2500;
   localparam logic [19:0] RESET_GAIN_RST  = 20'd250000;
   localparam logic [23:0] QUIET_TIME_RST  = 24'd250000;
   localparam logic [23:0] ACTIVE_TIME_RST = 24'd500000;
   localparam logic [14:0] GYRO_LIMIT_RST  = 15'd240;
   localparam logic [15:0] ONE_G_RST       = 16'd2048;

   localparam logic [31:0] G2_RST     = 32'(ONE_G_RST) * 32'(ONE_G_RST);
   localparam logic [THR_W-1:0] THR_LO_RST = THR_W'(G2_RST) * THR_W'(81);
   localparam logic [THR_W-1:0] THR_HI_RST = THR_W'(G2_RST) * THR_W'(121);

   // rsp_tdata bit positions
   localparam int RSP_HEALTHY_BIT = 20;
   localparam int RSP_ACTIVE_BIT  = 21;

endpackage

[hw/rtl/attitude_gain_scheduler_core.sv]
`timescale 1ns / 1ps

// Attitude gain scheduler.
// req_*: one sensor sample per beat (time, armed flag, accel and gyro axes).
// rsp_*: one result per sample (gain, accel health flag, reset window flag).
// csr_*: register writes, taken on any clock with csr_we high; write only
//        while no sample is in flight.
// A sample passes from the stage 1 registers to the result register behind
// rsp_tvalid; one sample per clock when no result is stalled, in a two-deep
// pipeline (squares of the axes, then health test, timers and gain select).
// The timer state is updated as a sample moves into the result register.
// Reset: registers return to their defaults, both timers go idle, the
// pipeline empties and no result is shown.
// Stall: a result held by rsp_tready low stays on rsp_tdata; one more sample
// is taken into the first stage, after which req_tready drops until the
// result is taken.
module attitude_gain_scheduler_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // time_us[31:0], armed[32], acc_x[48:33], acc_y[64:49], acc_z[80:65],
   // rate_x[96:81], rate_y[112:97], rate_z[128:113], zero pad
   input  logic [ags_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // gain[19:0], acc_healthy[20], reset_active[21], zero pad
   output logic [ags_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [ags_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [ags_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ags_pkg::*;

   logic [15:0]       base_gain_ff;
   logic [19:0]       reset_gain_ff;
   logic [23:0]       quiet_time_ff;
   logic [23:0]       active_time_ff;
   logic [14:0]       gyro_limit_ff;
   logic [31:0]       g2_ff;
   logic [THR_W-1:0]  thr_lo_ff;
   logic [THR_W-1:0]  thr_hi_ff;

   logic              s1_valid_ff;
   logic [TIME_W-1:0] s1_time_ff;
   logic              s1_armed_ff;
   logic [SQ_W-1:0]   s1_sqx_ff, s1_sqy_ff, s1_sqz_ff;
   logic [MAG_W-1:0]  s1_rx_ff, s1_ry_ff, s1_rz_ff;

   logic                   out_valid_ff;
   logic [RSP_TDATA_W-1:0] out_data_ff;
   logic [RSP_TDATA_W-1:0] out_data_in;

   logic              was_armed_ff, was_armed_in;
   logic [TIME_W-1:0] quiet_end_ff, quiet_end_in;
   logic [TIME_W-1:0] window_end_ff, window_end_in;
   logic              reset_done_ff, reset_done_in;

   logic out_en, s1_en, st_en;

   logic [MAG_W-1:0] ax_mag, ay_mag, az_mag, rx_mag, ry_mag, rz_mag;
   logic [SUM_W-1:0] acc_sum;
   logic [THR_W-1:0] acc_sum100;
   logic             healthy, moving, active;
   logic [TIME_W-1:0] quiet_new, window_new;
   logic [GAIN_W-1:0] gain;

   function automatic logic [MAG_W-1:0] mag16(input logic [SAMPLE_W-1:0] v);
      logic [MAG_W-1:0] ext;
      ext = {v[SAMPLE_W-1], v};
      return v[SAMPLE_W-1] ? (MAG_W'(0) - ext) : ext;
   endfunction

   assign out_en     = !out_valid_ff || rsp_tready;
   assign s1_en      = !s1_valid_ff || out_en;
   assign st_en      = s1_valid_ff && out_en;
   assign req_tready = s1_en;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         base_gain_ff   <= BASE_GAIN_RST;
         reset_gain_ff  <= RESET_GAIN_RST;
         quiet_time_ff  <= QUIET_TIME_RST;
         active_time_ff <= ACTIVE_TIME_RST;
         gyro_limit_ff  <= GYRO_LIMIT_RST;
         g2_ff          <= G2_RST;
         thr_lo_ff      <= THR_LO_RST;
         thr_hi_ff      <= THR_HI_RST;
      end else begin
         thr_lo_ff <= THR_W'(g2_ff) * THR_W'(81);
         thr_hi_ff <= THR_W'(g2_ff) * THR_W'(121);
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_BASE_GAIN:   base_gain_ff   <= csr_wdata[15:0];
               CSR_RESET_GAIN:  reset_gain_ff  <= csr_wdata[19:0];
               CSR_QUIET_TIME:  quiet_time_ff  <= csr_wdata[23:0];
               CSR_ACTIVE_TIME: active_time_ff <= csr_wdata[23:0];
               CSR_GYRO_LIMIT:  gyro_limit_ff  <= csr_wdata[14:0];
               CSR_ONE_G:       g2_ff <= 32'(csr_wdata[15:0]) * 32'(csr_wdata[15:0]);
               default: ;
            endcase
         end
      end
   end

   // stage 1: magnitudes and squares
   assign ax_mag = mag16(req_tdata[48:33]);
   assign ay_mag = mag16(req_tdata[64:49]);
   assign az_mag = mag16(req_tdata[80:65]);
   assign rx_mag = mag16(req_tdata[96:81]);
   assign ry_mag = mag16(req_tdata[112:97]);
   assign rz_mag = mag16(req_tdata[128:113]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_time_ff  <= req_tdata[31:0];
         s1_armed_ff <= req_tdata[32];
         s1_sqx_ff   <= SQ_W'(34'(ax_mag) * 34'(ax_mag));
         s1_sqy_ff   <= SQ_W'(34'(ay_mag) * 34'(ay_mag));
         s1_sqz_ff   <= SQ_W'(34'(az_mag) * 34'(az_mag));
         s1_rx_ff    <= rx_mag;
         s1_ry_ff    <= ry_mag;
         s1_rz_ff    <= rz_mag;
      end
   end

   // stage 2: health test, timers, gain select
   assign acc_sum    = SUM_W'(s1_sqx_ff) + SUM_W'(s1_sqy_ff) + SUM_W'(s1_sqz_ff);
   assign acc_sum100 = THR_W'(acc_sum) * THR_W'(100);
   assign healthy    = (thr_lo_ff < acc_sum100) && (acc_sum100 < thr_hi_ff);
   assign moving     = (s1_rx_ff > MAG_W'(gyro_limit_ff))
                    || (s1_ry_ff > MAG_W'(gyro_limit_ff))
                    || (s1_rz_ff > MAG_W'(gyro_limit_ff));
   assign quiet_new  = s1_time_ff + TIME_W'(quiet_time_ff);
   assign window_new = s1_time_ff + TIME_W'(active_time_ff);

   always_comb begin
      quiet_end_in  = quiet_end_ff;
      window_end_in = window_end_ff;
      reset_done_in = reset_done_ff;
      was_armed_in  = s1_armed_ff;
      active        = 1'b0;
      if (!s1_armed_ff) begin
         if (was_armed_ff) begin
            quiet_end_in  = quiet_new;
            window_end_in = '0;
            reset_done_in = 1'b0;
         end
         if ((window_end_in != '0 || quiet_end_in != '0 || reset_done_in)
             && (moving || !healthy)) begin
            quiet_end_in  = quiet_new;
            window_end_in = '0;
         end
         if (window_end_in != '0) begin
            if (s1_time_ff >= window_end_in) begin
               quiet_end_in  = '0;
               window_end_in = '0;
               reset_done_in = 1'b1;
            end else begin
               active = 1'b1;
            end
         end else if (quiet_end_in != '0 && s1_time_ff >= quiet_end_in) begin
            window_end_in = window_new;
            quiet_end_in  = '0;
         end
      end
   end

   always_comb begin
      if (active) begin
         gain = reset_gain_ff;
      end else if (!s1_armed_ff) begin
         gain = GAIN_W'(base_gain_ff) * GAIN_W'(10);
      end else begin
         gain = GAIN_W'(base_gain_ff);
      end
      out_data_in = {2'b00, active, healthy, gain};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         was_armed_ff  <= 1'b0;
         quiet_end_ff  <= '0;
         window_end_ff <= '0;
         reset_done_ff <= 1'b0;
      end else if (st_en) begin
         was_armed_ff  <= was_armed_in;
         quiet_end_ff  <= quiet_end_in;
         window_end_ff <= window_end_in;
         reset_done_ff <= reset_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_en) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (st_en) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

[hw/rtl/ags_checker.sv]
`timescale 1ns / 1ps

module ags_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [ags_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import ags_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // reset window only opens on a healthy sample
   a_active_healthy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_ACTIVE_BIT] |-> rsp_tdata[RSP_HEALTHY_BIT])
      else $error("reset window reported with unhealthy accel");

   // an accepted beat reaches the result register and shows on rsp_tvalid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##2 rsp_tvalid)
      else $error("result missing two cycles after accept");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown after reset");

endmodule

bind attitude_gain_scheduler_core ags_checker u_ags_checker (.*);
